// File: hdl/cjsg_pkg.sv
// Package for the job schedule generator: constants, codes and cell types.
// No dependencies.
package cjsg_pkg;
    localparam int MAX_JOBS = 16;
    localparam int IDX_W    = $clog2(MAX_JOBS);
    localparam int CNT_W    = $clog2(MAX_JOBS + 1);
    localparam int TIME_W   = 20;
    localparam logic [TIME_W-1:0] TIME_MAX = '1;

    // chain is cut by a register between consecutive groups of cells
    localparam int CELLS_PER_STG = 4;
    localparam int N_STG         = MAX_JOBS / CELLS_PER_STG;
    localparam int STG_W         = $clog2(N_STG);
    // cycles spent refilling the stage cuts before the pick
    localparam int SCAN_WAIT     = N_STG - 2;

    localparam logic [1:0] FUNC_LOAD   = 2'd0;
    localparam logic [1:0] FUNC_NEXT   = 2'd1;
    localparam logic [1:0] FUNC_CLEAR  = 2'd2;
    localparam logic [1:0] FUNC_UNUSED = 2'd3;

    localparam logic [1:0] POL_FCFS = 2'd0;
    localparam logic [1:0] POL_RR   = 2'd1;
    localparam logic [1:0] POL_SJF  = 2'd2;
    localparam logic [1:0] POL_PRIO = 2'd3;

    localparam logic REG_POLICY  = 1'b0;
    localparam logic REG_QUANTUM = 1'b1;

    // candidate travelling along the chain of cells
    typedef struct packed {
        logic             found;
        logic [IDX_W-1:0] idx;
        logic [15:0]      rem;
        logic [15:0]      prio;
    } cand_t;

    typedef struct packed {
        logic [1:0]       policy;
        logic [IDX_W-1:0] start;
    } scan_ctl_t;
endpackage

// File: hdl/cjsg_if.sv
// Valid/ready channel interfaces for the schedule generator.
// Depends on cjsg_pkg.
interface cjsg_in_if;
    import cjsg_pkg::*;
    logic        valid;
    logic        ready;
    logic [1:0]  func;
    logic [15:0] job_size;
    logic signed [15:0] job_priority;
    modport source (output valid, func, job_size, job_priority, input ready);
    modport sink   (input valid, func, job_size, job_priority, output ready);
endinterface

interface cjsg_out_if;
    logic        valid;
    logic        ready;
    logic        event_valid;
    logic        event_kind;
    logic [3:0]  job_index;
    logic [19:0] event_time;
    logic        table_overflowed;
    modport source (output valid, event_valid, event_kind, job_index, event_time,
                    table_overflowed, input ready);
    modport sink   (input valid, event_valid, event_kind, job_index, event_time,
                    table_overflowed, output ready);
endinterface

interface cjsg_cfg_if;
    logic        valid;
    logic        ready;
    logic        index;
    logic [15:0] data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// File: hdl/cjsg_cell.sv
// One job slot: holds remaining work and priority, compares against the
// candidate passed in and hands the better one on. Depends on cjsg_pkg.
module cjsg_cell (
    input  logic                       clk,
    input  logic                       load_en,
    input  logic [15:0]                load_rem,
    input  logic [15:0]                load_prio,
    input  logic                       dec_en,
    input  logic [15:0]                dec_amt,
    input  logic [cjsg_pkg::IDX_W-1:0] my_idx,
    input  logic                       in_use,
    input  cjsg_pkg::scan_ctl_t        ctl,
    input  cjsg_pkg::cand_t            cand_in,
    output cjsg_pkg::cand_t            cand_out,
    output logic [15:0]                rem
);
    import cjsg_pkg::*;

    logic [15:0] rem_reg, prio_reg;
    logic        elig, better;

    // slot storage
    always_ff @(posedge clk)
    begin
        if (load_en)
        begin
            rem_reg  <= load_rem;
            prio_reg <= load_prio;
        end
        else if (dec_en)
            rem_reg <= rem_reg - dec_amt;
    end
    assign rem = rem_reg;

    // in use with work left; for RR the top clears in_use of slots before start
    assign elig = in_use && (rem_reg != '0);

    always_comb
    begin
        unique case (ctl.policy)
            POL_SJF:  better = rem_reg < cand_in.rem;
            POL_PRIO: better = $signed(prio_reg) > $signed(cand_in.prio);
            default:  better = 1'b0;
        endcase
        if (elig && (!cand_in.found || better))
        begin
            cand_out.found = 1'b1;
            cand_out.idx   = my_idx;
            cand_out.rem   = rem_reg;
            cand_out.prio  = prio_reg;
        end
        else
            cand_out = cand_in;
    end
endmodule

// File: hdl/cpu_job_schedule_generator_top.sv
// Top: a chain of slot cells picks the next job; FCFS uses a first-unserved scan.
// Next requests: after accept the block waits while the registered cuts of the
// chain refill, then picks, updates the table and registers the result; the next
// item is accepted only once that result has been taken, so output stalls hold it off.
// Loads, clears and unused codes complete at accept and do not make the block busy.
// Reset (rst_n, async low) empties the table, zeroes time and flags,
// sets policy to first come first served and quantum to 1.
// Depends on cjsg_pkg, cjsg_if and cjsg_cell.
module cpu_job_schedule_generator_top (
    input  logic clk,
    input  logic rst_n,
    cjsg_in_if.sink    in_ch,
    cjsg_out_if.source out_ch,
    cjsg_cfg_if.sink   cfg
);
    import cjsg_pkg::*;

    logic [1:0]          policy_reg;
    logic [15:0]         quantum_reg;
    logic [MAX_JOBS-1:0] served_reg;
    logic [CNT_W-1:0]    count_reg;
    logic [IDX_W-1:0]    cur_reg;
    logic                stop_reg, ovf_reg, ran_reg;
    logic [TIME_W:0]     time_reg;
    logic                busy_reg, ovalid_reg;
    logic [STG_W-1:0]    scan_cnt_reg;
    logic                evv_reg, evk_reg;
    logic [3:0]          eidx_reg;
    logic [TIME_W-1:0]   etime_reg;
    logic                eovf_reg;

    logic in_acc, do_load, do_next, do_pick;
    cand_t cin [MAX_JOBS];
    cand_t cout [MAX_JOBS];
    cand_t chain2 [MAX_JOBS+1];
    logic [15:0] rems [MAX_JOBS];
    logic [MAX_JOBS-1:0] in_use;
    scan_ctl_t ctl;
    logic [IDX_W-1:0] start;
    logic [CNT_W:0] start_w;
    cand_t pick;
    logic [15:0] q, run;
    logic [TIME_W+1:0] tsum;
    logic fcfs_found;
    logic [IDX_W-1:0] fcfs_idx;

    assign cfg.ready  = 1'b1;
    assign in_ch.ready = !busy_reg && !ovalid_reg;
    assign in_acc  = in_ch.valid && in_ch.ready;
    assign do_load = in_acc && in_ch.func == FUNC_LOAD && count_reg < CNT_W'(MAX_JOBS);
    assign do_next = busy_reg && scan_cnt_reg == '0;
    assign do_pick = do_next && !stop_reg;

    // start slot for round robin
    always_comb
    begin
        start_w = (CNT_W+1)'(cur_reg) + 1'b1;
        if (!ran_reg || start_w >= (CNT_W+1)'(count_reg))
            start = '0;
        else
            start = start_w[IDX_W-1:0];
        ctl.policy = policy_reg;
        ctl.start  = start;
    end

    // cells
    assign chain2[0] = '0;
    for (genvar i = 0; i < MAX_JOBS; i++)
    begin : g_cell
        logic [IDX_W-1:0] idx_c;
        cand_t            dummy;
        assign idx_c = IDX_W'(i);
        assign in_use[i] = CNT_W'(i) < count_reg;

        // chain input: empty at the head, registered at each group boundary
        if (i == 0)
        begin : g_head
            assign cin[i] = '0;
        end
        else if (i % CELLS_PER_STG == 0)
        begin : g_cut
            cand_t cut_reg;
            always_ff @(posedge clk)
                cut_reg <= cout[i-1];
            assign cin[i] = cut_reg;
        end
        else
        begin : g_pass
            assign cin[i] = cout[i-1];
        end

        cjsg_cell u_cell (
            .clk      (clk),
            .load_en  (do_load && count_reg[IDX_W-1:0] == idx_c),
            .load_rem (in_ch.job_size),
            .load_prio(in_ch.job_priority),
            .dec_en   (do_pick && pick.found && pick.idx == idx_c),
            .dec_amt  (run),
            .my_idx   (idx_c),
            .in_use   (in_use[i] && (ctl.policy != POL_RR || idx_c >= start)),
            .ctl      (ctl),
            .cand_in  (cin[i]),
            .cand_out (cout[i]),
            .rem      (rems[i])
        );
        // wrap pass for round robin: slots before start
        always_comb
        begin
            if (!chain2[i].found && in_use[i] && idx_c < start && rems[i] != '0)
            begin
                dummy.found = 1'b1;
                dummy.idx = idx_c;
                dummy.rem = rems[i];
                dummy.prio = '0;
            end
            else
                dummy = chain2[i];
        end
        assign chain2[i+1] = dummy;
    end

    // first unserved slot for FCFS
    always_comb
    begin
        fcfs_found = 1'b0;
        fcfs_idx   = '0;
        for (int i = MAX_JOBS - 1; i >= 0; i--)
            if (in_use[i] && !served_reg[i])
            begin
                fcfs_found = 1'b1;
                fcfs_idx   = IDX_W'(i);
            end
    end

    always_comb
    begin
        pick = cout[MAX_JOBS-1];
        if (policy_reg == POL_FCFS)
        begin
            pick.found = fcfs_found;
            pick.idx   = fcfs_idx;
            pick.rem   = rems[fcfs_idx];
        end
        else if (policy_reg == POL_RR && !pick.found)
            pick = chain2[MAX_JOBS];
        q   = (quantum_reg == '0) ? 16'd1 : quantum_reg;
        run = (policy_reg == POL_RR && pick.rem > q) ? q : pick.rem;
        tsum = (TIME_W+2)'(time_reg) + (TIME_W+2)'(run);
    end

    // control and result registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            policy_reg <= POL_FCFS; quantum_reg <= 16'd1;
            served_reg <= '0; count_reg <= '0; cur_reg <= '0;
            stop_reg <= 1'b0; ovf_reg <= 1'b0; ran_reg <= 1'b0; time_reg <= '0;
            busy_reg <= 1'b0; ovalid_reg <= 1'b0; scan_cnt_reg <= '0;
        end
        else
        begin
            if (cfg.valid && cfg.index == REG_POLICY) policy_reg <= cfg.data[1:0];
            if (cfg.valid && cfg.index == REG_QUANTUM) quantum_reg <= cfg.data;
            if (ovalid_reg && out_ch.ready) ovalid_reg <= 1'b0;
            if (in_acc)
            begin
                priority case (in_ch.func)
                    FUNC_LOAD:
                        if (do_load)
                        begin
                            served_reg[count_reg[IDX_W-1:0]] <= 1'b0;
                            count_reg <= count_reg + 1'b1;
                        end
                        else
                            ovf_reg <= 1'b1;
                    FUNC_NEXT:
                    begin
                        busy_reg     <= 1'b1;
                        scan_cnt_reg <= STG_W'(SCAN_WAIT);
                    end
                    FUNC_CLEAR:
                    begin
                        served_reg <= '0; count_reg <= '0; cur_reg <= '0;
                        stop_reg <= 1'b0; time_reg <= '0; ovf_reg <= 1'b0;
                        ran_reg <= 1'b0;
                    end
                    default: ;
                endcase
            end
            if (do_next)
            begin
                busy_reg   <= 1'b0;
                ovalid_reg <= 1'b1;
                if (stop_reg)
                    stop_reg <= 1'b0;
                else if (pick.found)
                begin
                    if (pick.rem == run) served_reg[pick.idx] <= 1'b1;
                    time_reg <= (tsum > (TIME_W+2)'(TIME_MAX)) ? {1'b0, TIME_MAX}
                                                              : tsum[TIME_W:0];
                    cur_reg  <= pick.idx;
                    stop_reg <= 1'b1;
                    ran_reg  <= 1'b1;
                end
            end
            else if (busy_reg)
                scan_cnt_reg <= scan_cnt_reg - 1'b1;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (do_next)
        begin
            eovf_reg  <= ovf_reg;
            etime_reg <= time_reg[TIME_W-1:0];
            evk_reg   <= stop_reg;
            evv_reg   <= stop_reg || pick.found;
            eidx_reg  <= stop_reg ? 4'(cur_reg) : (pick.found ? 4'(pick.idx) : 4'd0);
        end
    end

    assign out_ch.valid            = ovalid_reg;
    assign out_ch.event_valid      = evv_reg;
    assign out_ch.event_kind       = evk_reg;
    assign out_ch.job_index        = eidx_reg;
    assign out_ch.event_time       = etime_reg;
    assign out_ch.table_overflowed = eovf_reg;

    // checks
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> !in_ch.ready) else $error("accept while busy");
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        do_next |=> ovalid_reg) else $error("result missing");
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAX_JOBS)) else $error("count overflow");
endmodule
